### hdl/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg: shared types and constants of the smooth damp block
// Q16.16 widths, constant factors of the decay polynomial, register indexes,
// the coefficient bundle and the result bundle of one lane.
// ----------------------------------------------------------------------------
package vsd_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SMOOTH_TIME = 2'd0,
		REG_MAX_SPEED   = 2'd1,
		REG_TIME_STEP   = 2'd2
	} cfg_reg_t;

	localparam logic [30:0] ST_RESET = 31'd65536;
	localparam logic [30:0] MS_RESET = 31'h7FFF_FFFF;
	localparam logic [15:0] TS_RESET = 16'd1092;

	// 0.0001 in Q16.16, rounded to the nearest code.
	localparam logic [30:0] ST_FLOOR = 31'd7;

	// 0.48 and 0.235 as Q0.16 fractions.
	localparam logic [14:0] K048 = 15'd31457;
	localparam logic [13:0] K0235 = 14'd15401;

	// Beyond 256.0 the decay factor is taken as zero.
	localparam logic [30:0] X_LIMIT = 31'd16777216;

	typedef struct packed {
		logic [30:0] omega;
		logic [15:0] ts;
		logic [16:0] decay;
		logic [45:0] maxc;
	} coef_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] tgt;
		logic signed [60:0] nv;
		logic signed [65:0] dp;
	} lane_res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hdl/vsd_if.sv
// ----------------------------------------------------------------------------
// vsd_if: channel interfaces of the smooth damp block
// Input items, result items and register writes, each with valid and ready.
// ----------------------------------------------------------------------------
interface vsd_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] current_x;
	logic signed [31:0] current_y;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;

	modport source(output valid, output current_x, output current_y,
		output target_x, output target_y, input ready);
	modport sink(input valid, input current_x, input current_y,
		input target_x, input target_y, output ready);
endinterface

interface vsd_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic               snapped;

	modport source(output valid, output out_x, output out_y, output snapped,
		input ready);
	modport sink(input valid, input out_x, input out_y, input snapped,
		output ready);
endinterface

interface vsd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [vsd_pkg::CFG_IDX_W-1:0]  index;
	logic [vsd_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### hdl/vsd_coef.sv
// ----------------------------------------------------------------------------
// vsd_coef: configuration registers and coefficient sequencer
// Holds the registers and derives omega, the decay factor and the offset
// limit from them with one shared restoring divider and a few multiplies.
// ----------------------------------------------------------------------------
module vsd_coef (
	input  logic          clk,
	input  logic          arst_n,
	vsd_cfg_if.sink       cfg,
	output vsd_pkg::coef_t coef,
	output logic          rdy
);

	typedef enum logic [8:0] {
		C_START     = 9'b0_0000_0001,
		C_DIV_OMEGA = 9'b0_0000_0010,
		C_MUL_X     = 9'b0_0000_0100,
		C_MUL_X2    = 9'b0_0000_1000,
		C_MUL_X3    = 9'b0_0001_0000,
		C_TERMS     = 9'b0_0010_0000,
		C_DEN       = 9'b0_0100_0000,
		C_DIV_DECAY = 9'b0_1000_0000,
		C_DONE      = 9'b1_0000_0000
	} cstate_t;

	localparam logic [5:0]  DIV_STEPS = 6'd34;
	localparam logic [33:0] OMEGA_NUM = 34'h2_0000_0000;
	localparam logic [33:0] DECAY_NUM = 34'h1_0000_0000;
	localparam logic [41:0] ONE_Q16 = 42'd65536;

	cstate_t     state_q;
	logic [5:0]  cnt_q;
	logic [30:0] st_q;
	logic [30:0] ms_q;
	logic [15:0] ts_q;

	logic [41:0] rem_q;
	logic [33:0] num_q;
	logic [41:0] dvs_q;
	logic [33:0] quo_q;
	logic [30:0] omega_q;
	logic [30:0] x_q;
	logic [32:0] x2_q;
	logic [40:0] x3_q;
	logic [31:0] t2_q;
	logic [38:0] t3_q;
	logic [16:0] decay_q;
	logic [45:0] maxc_q;

	logic [30:0] st_eff;
	logic [42:0] rem_sh;
	logic [43:0] diff;
	logic        qbit;
	logic [41:0] rem_next;
	logic [46:0] xprod;
	logic [61:0] mprod;
	logic [49:0] x2prod;
	logic [57:0] x3prod;
	logic [47:0] t2prod;
	logic [54:0] t3prod;
	logic [41:0] den;
	logic        cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire = cfg.valid;

	assign st_eff = (st_q < vsd_pkg::ST_FLOOR) ? vsd_pkg::ST_FLOOR : st_q;

	// One quotient bit per cycle, most significant first.
	assign rem_sh = {rem_q, num_q[33]};
	assign diff = {1'b0, rem_sh} - {2'b0, dvs_q};
	assign qbit = ~diff[43];
	assign rem_next = qbit ? diff[41:0] : rem_sh[41:0];

	assign xprod = omega_q * ts_q;
	assign mprod = ms_q * st_eff;
	assign x2prod = x_q[24:0] * x_q[24:0];
	assign x3prod = x2_q * x_q[24:0];
	assign t2prod = x2_q * vsd_pkg::K048;
	assign t3prod = x3_q * vsd_pkg::K0235;
	assign den = ONE_Q16 + {11'b0, x_q} + {10'b0, t2_q} + {3'b0, t3_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_START;
			cnt_q <= '0;
			st_q <= vsd_pkg::ST_RESET;
			ms_q <= vsd_pkg::MS_RESET;
			ts_q <= vsd_pkg::TS_RESET;
		end else if (cfg_fire) begin
			case (cfg.index)
				vsd_pkg::REG_SMOOTH_TIME: st_q <= cfg.data[30:0];
				vsd_pkg::REG_MAX_SPEED:   ms_q <= cfg.data[30:0];
				vsd_pkg::REG_TIME_STEP:   ts_q <= cfg.data[15:0];
				default: ;
			endcase
			state_q <= C_START;
		end else begin
			case (state_q)
				C_START: begin
					state_q <= C_DIV_OMEGA;
					cnt_q <= DIV_STEPS;
				end
				C_DIV_OMEGA: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 6'd1;
					end else begin
						state_q <= C_MUL_X;
					end
				end
				C_MUL_X:  state_q <= C_MUL_X2;
				C_MUL_X2: state_q <= C_MUL_X3;
				C_MUL_X3: state_q <= C_TERMS;
				C_TERMS:  state_q <= C_DEN;
				C_DEN: begin
					if (x_q > vsd_pkg::X_LIMIT) begin
						state_q <= C_DONE;
					end else begin
						state_q <= C_DIV_DECAY;
						cnt_q <= DIV_STEPS;
					end
				end
				C_DIV_DECAY: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 6'd1;
					end else begin
						state_q <= C_DONE;
					end
				end
				C_DONE: ;
				default: state_q <= C_START;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			C_START: begin
				rem_q <= '0;
				num_q <= OMEGA_NUM;
				dvs_q <= {11'b0, st_eff};
			end
			C_DIV_OMEGA: begin
				if (cnt_q != '0) begin
					rem_q <= rem_next;
					num_q <= {num_q[32:0], 1'b0};
					quo_q <= {quo_q[32:0], qbit};
				end else begin
					omega_q <= quo_q[30:0];
				end
			end
			C_MUL_X: begin
				x_q <= xprod[46:16];
				maxc_q <= mprod[61:16];
			end
			C_MUL_X2: x2_q <= x2prod[48:16];
			C_MUL_X3: x3_q <= x3prod[56:16];
			C_TERMS: begin
				t2_q <= t2prod[47:16];
				t3_q <= t3prod[54:16];
			end
			C_DEN: begin
				if (x_q > vsd_pkg::X_LIMIT) begin
					decay_q <= '0;
				end else begin
					rem_q <= '0;
					num_q <= DECAY_NUM;
					dvs_q <= den;
				end
			end
			C_DIV_DECAY: begin
				if (cnt_q != '0) begin
					rem_q <= rem_next;
					num_q <= {num_q[32:0], 1'b0};
					quo_q <= {quo_q[32:0], qbit};
				end else begin
					decay_q <= quo_q[16:0];
				end
			end
			default: ;
		endcase
	end

	assign coef.omega = omega_q;
	assign coef.ts = ts_q;
	assign coef.decay = decay_q;
	assign coef.maxc = maxc_q;
	assign rdy = (state_q == C_DONE);

endmodule

### hdl/vsd_lane.sv
// ----------------------------------------------------------------------------
// vsd_lane: spring update of one axis
// Eight register stages: offset clamp, spring force, velocity step, decay,
// new position, and the axis term of the overshoot dot product.
// ----------------------------------------------------------------------------
module vsd_lane (
	input  logic               clk,
	input  logic               adv,
	input  logic signed [31:0] cur,
	input  logic signed [31:0] tgt,
	input  logic signed [31:0] vel,
	input  vsd_pkg::coef_t     coef,
	output vsd_pkg::lane_res_t res
);

	logic signed [31:0] om_s;
	logic signed [16:0] ts_s;
	logic signed [17:0] dc_s;

	logic signed [47:0] diff_w;
	logic signed [47:0] maxc_w;
	logic signed [47:0] chc_w;

	logic signed [31:0] cur_s1, cur_s2, cur_s3, cur_s4, cur_s5, cur_s6, cur_s7;
	logic signed [31:0] tgt_s1, tgt_s2, tgt_s3, tgt_s4, tgt_s5, tgt_s6, tgt_s7, tgt_s8;
	logic signed [32:0] ch_s1, ch_s2, ch_s3, ch_s4, ch_s5, ch_s6;

	logic signed [48:0] a_s2;
	logic signed [49:0] sv_s3;
	logic signed [49:0] tm_s4;
	logic signed [57:0] ph_s5;
	logic        [54:0] pl_s5;
	logic signed [50:0] u_s5;
	logic signed [58:0] b_s6;
	logic signed [52:0] off_s6;
	logic signed [58:0] w_s7;
	logic signed [31:0] pos_s7;
	logic signed [60:0] nv_s8;
	logic signed [65:0] dp_s8;
	logic signed [31:0] pos_s8;

	logic signed [64:0] prod1;
	logic signed [66:0] prod2;
	logic signed [25:0] tm_hi;
	logic signed [57:0] ph;
	logic        [54:0] pl;
	logic signed [68:0] prod3;
	logic signed [76:0] prod4;
	logic signed [53:0] possum;
	logic signed [32:0] dvec;
	logic signed [32:0] evec;
	logic signed [65:0] dp;

	assign om_s = {1'b0, coef.omega};
	assign ts_s = {1'b0, coef.ts};
	assign dc_s = {1'b0, coef.decay};

	// The offset is limited to max_speed times smooth_time on each axis.
	always_comb begin
		diff_w = {{16{cur[31]}}, cur} - {{16{tgt[31]}}, tgt};
		maxc_w = {2'b0, coef.maxc};
		chc_w = diff_w;
		if (diff_w > maxc_w) begin
			chc_w = maxc_w;
		end else if (diff_w < -maxc_w) begin
			chc_w = -maxc_w;
		end
	end

	assign prod1 = ch_s1 * om_s;
	assign prod2 = sv_s3 * ts_s;
	// tm times omega is split at bit 24 so that each partial product stays narrow.
	assign tm_hi = tm_s4[49:24];
	assign ph = tm_hi * om_s;
	assign pl = tm_s4[23:0] * coef.omega;
	assign prod3 = u_s5 * dc_s;
	assign prod4 = w_s7 * dc_s;
	assign possum = {{22{cur_s6[31]}}, cur_s6} - {{21{ch_s6[32]}}, ch_s6}
		+ {off_s6[52], off_s6};
	assign dvec = {tgt_s7[31], tgt_s7} - {cur_s7[31], cur_s7};
	assign evec = {pos_s7[31], pos_s7} - {tgt_s7[31], tgt_s7};
	assign dp = dvec * evec;

	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s1 <= cur;
			tgt_s1 <= tgt;
			ch_s1 <= chc_w[32:0];

			a_s2 <= prod1[64:16];
			cur_s2 <= cur_s1;
			tgt_s2 <= tgt_s1;
			ch_s2 <= ch_s1;

			sv_s3 <= {{18{vel[31]}}, vel} + {a_s2[48], a_s2};
			cur_s3 <= cur_s2;
			tgt_s3 <= tgt_s2;
			ch_s3 <= ch_s2;

			tm_s4 <= prod2[65:16];
			cur_s4 <= cur_s3;
			tgt_s4 <= tgt_s3;
			ch_s4 <= ch_s3;

			ph_s5 <= ph;
			pl_s5 <= pl;
			u_s5 <= {{18{ch_s4[32]}}, ch_s4} + {tm_s4[49], tm_s4};
			cur_s5 <= cur_s4;
			tgt_s5 <= tgt_s4;
			ch_s5 <= ch_s4;

			b_s6 <= {ph_s5[50:0], 8'b0} + {20'b0, pl_s5[54:16]};
			off_s6 <= prod3[68:16];
			cur_s6 <= cur_s5;
			tgt_s6 <= tgt_s5;
			ch_s6 <= ch_s5;

			w_s7 <= {{27{vel[31]}}, vel} - b_s6;
			pos_s7 <= vsd_pkg::sat32({{10{possum[53]}}, possum});
			cur_s7 <= cur_s6;
			tgt_s7 <= tgt_s6;

			nv_s8 <= prod4[76:16];
			dp_s8 <= dp;
			pos_s8 <= pos_s7;
			tgt_s8 <= tgt_s7;
		end
	end

	assign res.pos = pos_s8;
	assign res.tgt = tgt_s8;
	assign res.nv = nv_s8;
	assign res.dp = dp_s8;

endmodule

### hdl/vsd_merge.sv
// ----------------------------------------------------------------------------
// vsd_merge: overshoot test, velocity state and result register
// Adds the two axis terms of the dot product, snaps to the target when it is
// positive, and updates the stored velocity.
// ----------------------------------------------------------------------------
module vsd_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  vsd_pkg::lane_res_t res_x,
	input  vsd_pkg::lane_res_t res_y,
	vsd_out_if.source          result,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic               hold
);

	logic signed [65:0] dp_x;
	logic signed [65:0] dp_y;
	logic signed [66:0] dsum;
	logic               snap;
	logic signed [60:0] nv_x;
	logic signed [60:0] nv_y;

	logic               valid_q;
	logic signed [31:0] vel_x_q;
	logic signed [31:0] vel_y_q;
	logic signed [31:0] out_x_q;
	logic signed [31:0] out_y_q;
	logic               snapped_q;

	assign dp_x = res_x.dp;
	assign dp_y = res_y.dp;
	assign nv_x = res_x.nv;
	assign nv_y = res_y.nv;
	assign dsum = {dp_x[65], dp_x} + {dp_y[65], dp_y};
	assign snap = (dsum > 67'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vel_x_q <= '0;
			vel_y_q <= '0;
		end else if (fire) begin
			valid_q <= 1'b1;
			if (snap) begin
				vel_x_q <= '0;
				vel_y_q <= '0;
			end else begin
				vel_x_q <= vsd_pkg::sat32({{3{nv_x[60]}}, nv_x});
				vel_y_q <= vsd_pkg::sat32({{3{nv_y[60]}}, nv_y});
			end
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_x_q <= snap ? res_x.tgt : res_x.pos;
			out_y_q <= snap ? res_y.tgt : res_y.pos;
			snapped_q <= snap;
		end
	end

	assign result.valid = valid_q;
	assign result.out_x = out_x_q;
	assign result.out_y = out_y_q;
	assign result.snapped = snapped_q;
	assign vel_x = vel_x_q;
	assign vel_y = vel_y_q;
	assign hold = valid_q & ~result.ready;

endmodule

### hdl/vector_smooth_damp.sv
// ----------------------------------------------------------------------------
// vector_smooth_damp: 2D critically damped spring smoother
// A request passes the eight stages of the two axis lanes and the result
// register; the velocity fed back through the lanes means a new request is
// accepted only once the previous one has left the lanes.
// Reset clears the velocity and loads the register defaults; after reset and
// after every register write, input ready stays low while the coefficients
// are derived.
// ----------------------------------------------------------------------------
module vector_smooth_damp (
	input  logic      clk,
	input  logic      arst_n,
	vsd_in_if.sink    item,
	vsd_out_if.source result,
	vsd_cfg_if.sink   cfg
);

	vsd_pkg::coef_t     coef;
	vsd_pkg::lane_res_t res_x;
	vsd_pkg::lane_res_t res_y;
	logic               coef_rdy;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic               hold;
	logic               adv;
	logic               fire;
	logic               in_rdy;
	logic               accept;
	logic [7:0]         v_q;

	vsd_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef),
		.rdy    (coef_rdy)
	);

	// The pipeline only stops when a finished request waits on a full result register.
	assign adv = ~(v_q[7] & hold);
	assign fire = v_q[7] & adv;
	assign in_rdy = coef_rdy & (v_q[6:0] == '0) & (~v_q[7] | adv);
	assign accept = item.valid & in_rdy;
	assign item.ready = in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[6:0], accept};
		end
	end

	vsd_lane u_lane_x (
		.clk  (clk),
		.adv  (adv),
		.cur  (item.current_x),
		.tgt  (item.target_x),
		.vel  (vel_x),
		.coef (coef),
		.res  (res_x)
	);

	vsd_lane u_lane_y (
		.clk  (clk),
		.adv  (adv),
		.cur  (item.current_y),
		.tgt  (item.target_y),
		.vel  (vel_y),
		.coef (coef),
		.res  (res_y)
	);

	vsd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.res_x  (res_x),
		.res_y  (res_y),
		.result (result),
		.vel_x  (vel_x),
		.vel_y  (vel_y),
		.hold   (hold)
	);

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 2D smooth damp block
// Feeds current/target position pairs through several register settings and
// checks every result against a bit-exact spring predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vsd_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
	} pos_req_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               snapped;
	} damp_res_t;

	localparam wide_t WIDE_SAT = 128'sh1FFF_FFFF_FFFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_100 = 32'sd6553600;
	localparam int PHASE_ITEMS = 130;
	localparam int RANDOM_ITEMS = 1450;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;

	vsd_in_if  in_ch();
	vsd_out_if res_ch();
	vsd_cfg_if cfg_ch();

	vector_smooth_damp i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor copy of the registers and the velocity.
	logic [30:0]        st_cfg = ST_RESET;
	logic [30:0]        ms_cfg = MS_RESET;
	logic [15:0]        ts_cfg = TS_RESET;
	logic signed [31:0] vel_x_q = '0;
	logic signed [31:0] vel_y_q = '0;

	pos_req_t  pending_moves[$];
	damp_res_t expected_moves[$];

	int  moves_issued = 0;
	int  results_seen = 0;
	int  random_issued = 0;
	int  idle_cycles = 0;
	int  gap_left = 0;
	int  burst_left = 1;
	int  stall_run = 0;
	bit  ready_lvl = 1'b0;
	bit  mismatch_seen = 1'b0;
	logic in_taken = 1'b0;
	logic cfg_taken = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic wide_t wide_sat(input wide_t v);
		if (v > WIDE_SAT) begin
			return WIDE_SAT;
		end else if (v < -WIDE_SAT) begin
			return -WIDE_SAT;
		end
		return v;
	endfunction

	// Q16.16 product, rounded toward minus infinity.
	function automatic wide_t fx_mul(input wide_t a, input wide_t b);
		wide_t p;
		p = (a * b) >>> 16;
		return wide_sat(p);
	endfunction

	function automatic wide_t clamp32(input wide_t v);
		wide_t hi, lo;
		hi = Q_MAX;
		lo = Q_MIN;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic longint to_q(input longint v);
		if (v > longint'(Q_MAX)) begin
			return longint'(Q_MAX);
		end else if (v < longint'(Q_MIN)) begin
			return longint'(Q_MIN);
		end
		return v;
	endfunction

	// Signed value of about 'bits' bits of magnitude.
	function automatic logic signed [31:0] rnd_val(input int bits);
		logic signed [31:0] v;
		v = $urandom;
		return v >>> (31 - bits);
	endfunction

	// One spring update; advances the predictor's velocity.
	function automatic damp_res_t smooth_damp_step(input pos_req_t m);
		damp_res_t r;
		longint unsigned st, omega, x, x2, x3, den;
		wide_t decay, maxc, msw, stw, om, ts, cx, cy, tx, ty, chx, chy;
		wide_t tmx, tmy, nvx, nvy, ox, oy, dot;
		st = (st_cfg < ST_FLOOR) ? ST_FLOOR : st_cfg;
		omega = (64'd1 << 33) / st;
		x = (omega * ts_cfg) >> 16;
		decay = 0;
		if (x <= X_LIMIT) begin
			x2 = (x * x) >> 16;
			x3 = (x2 * x) >> 16;
			den = 64'd65536 + x + ((x2 * K048) >> 16) + ((x3 * K0235) >> 16);
			decay = (64'd1 << 32) / den;
		end
		msw = ms_cfg;
		stw = st;
		om = omega;
		ts = ts_cfg;
		cx = m.cx;
		cy = m.cy;
		tx = m.tx;
		ty = m.ty;
		maxc = fx_mul(msw, stw);
		chx = cx - tx;
		chy = cy - ty;
		if (chx > maxc) chx = maxc;
		if (chx < -maxc) chx = -maxc;
		if (chy > maxc) chy = maxc;
		if (chy < -maxc) chy = -maxc;
		tmx = fx_mul(wide_sat(vel_x_q + fx_mul(chx, om)), ts);
		tmy = fx_mul(wide_sat(vel_y_q + fx_mul(chy, om)), ts);
		nvx = fx_mul(wide_sat(vel_x_q - fx_mul(tmx, om)), decay);
		nvy = fx_mul(wide_sat(vel_y_q - fx_mul(tmy, om)), decay);
		ox = clamp32((cx - chx) + fx_mul(wide_sat(chx + tmx), decay));
		oy = clamp32((cy - chy) + fx_mul(wide_sat(chy + tmy), decay));
		// Overshoot: the step carried the position past the target.
		dot = (tx - cx) * (ox - tx) + (ty - cy) * (oy - ty);
		if (dot > 0) begin
			r.x = m.tx;
			r.y = m.ty;
			r.snapped = 1'b1;
			vel_x_q = '0;
			vel_y_q = '0;
		end else begin
			r.x = ox[31:0];
			r.y = oy[31:0];
			r.snapped = 1'b0;
			vel_x_q = clamp32(nvx) >>> 0;
			vel_y_q = clamp32(nvy) >>> 0;
		end
		return r;
	endfunction

	task automatic add_move(input logic signed [31:0] cx, input logic signed [31:0] cy,
		input logic signed [31:0] tx, input logic signed [31:0] ty);
		pos_req_t m;
		m.cx = cx;
		m.cy = cy;
		m.tx = tx;
		m.ty = ty;
		pending_moves.push_back(m);
		moves_issued++;
	endtask

	// Mostly tracking runs, where the position closes in on a target that
	// jumps now and then, with some fully random requests mixed in.
	task automatic queue_random_items(input int count);
		longint px, py;
		logic signed [31:0] gx, gy;
		int bits, run_left;
		run_left = 0;
		bits = 31;
		px = 0;
		py = 0;
		gx = '0;
		gy = '0;
		repeat (count) begin
			if ($urandom_range(0, 9) < 2) begin
				add_move($urandom, $urandom, $urandom, $urandom);
			end else begin
				if (run_left == 0) begin
					bits = $urandom_range(0, 31);
					gx = rnd_val(bits);
					gy = rnd_val(bits);
					px = to_q(longint'(gx) + rnd_val(bits));
					py = to_q(longint'(gy) + rnd_val(bits));
					run_left = $urandom_range(4, 40);
				end
				add_move(px[31:0], py[31:0], gx, gy);
				run_left--;
				if ($urandom_range(0, 15) == 0) begin
					gx = rnd_val(bits);
					gy = rnd_val(bits);
				end
				px = to_q(px + ((longint'(gx) - px) >>> $urandom_range(1, 4))
					+ rnd_val(bits > 6 ? bits - 6 : 0));
				py = to_q(py + ((longint'(gy) - py) >>> $urandom_range(1, 4))
					+ rnd_val(bits > 6 ? bits - 6 : 0));
			end
		end
		random_issued += count;
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (results_seen < moves_issued);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(negedge clk); while (!cfg_taken);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] st, input logic [31:0] ms,
		input logic [31:0] ts);
		wait_idle();
		write_reg(REG_SMOOTH_TIME, st);
		write_reg(REG_MAX_SPEED, ms);
		write_reg(REG_TIME_STEP, ts);
		queue_random_items(PHASE_ITEMS);
	endtask

	// Input side: bursts of requests separated by random gaps.
	always @(negedge clk) begin
		pos_req_t m;
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending_moves.size() > 0) begin
				m = pending_moves.pop_front();
				in_ch.current_x <= m.cx;
				in_ch.current_y <= m.cy;
				in_ch.target_x <= m.tx;
				in_ch.target_y <= m.ty;
				in_ch.valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result side: short random stalls with occasional long ready stretches.
	always @(negedge clk) begin
		if (stall_run == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				ready_lvl = 1'b1;
				stall_run = $urandom_range(30, 120);
			end else begin
				ready_lvl = $urandom_range(0, 1);
				stall_run = $urandom_range(1, 9);
			end
		end
		stall_run--;
		res_ch.ready <= ready_lvl;
	end

	always @(posedge clk) begin
		pos_req_t  m;
		damp_res_t want;
		in_taken <= in_ch.valid && in_ch.ready;
		cfg_taken <= cfg_ch.valid && cfg_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (expected_moves.size() == 0) begin
				$error("result with nothing pending: out_x %0d out_y %0d snapped %0b",
					res_ch.out_x, res_ch.out_y, res_ch.snapped);
				mismatch_seen = 1'b1;
			end else begin
				want = expected_moves.pop_front();
				if (res_ch.out_x !== want.x) begin
					$error("out_x: expected %0d, got %0d", want.x, res_ch.out_x);
					mismatch_seen = 1'b1;
				end
				if (res_ch.out_y !== want.y) begin
					$error("out_y: expected %0d, got %0d", want.y, res_ch.out_y);
					mismatch_seen = 1'b1;
				end
				if (res_ch.snapped !== want.snapped) begin
					$error("snapped: expected %0b, got %0b", want.snapped, res_ch.snapped);
					mismatch_seen = 1'b1;
				end
			end
		end
		if (arst_n && in_ch.valid && in_ch.ready) begin
			m.cx = in_ch.current_x;
			m.cy = in_ch.current_y;
			m.tx = in_ch.target_x;
			m.ty = in_ch.target_y;
			expected_moves.push_back(smooth_damp_step(m));
		end
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_SMOOTH_TIME: st_cfg = cfg_ch.data[30:0];
				REG_MAX_SPEED:   ms_cfg = cfg_ch.data[30:0];
				REG_TIME_STEP:   ts_cfg = cfg_ch.data[15:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[vector_smooth_damp] ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] st, ms, ts;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.current_x = '0;
		in_ch.current_y = '0;
		in_ch.target_x = '0;
		in_ch.target_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Register defaults: extreme positions, then a velocity built up
		// toward a target that is then passed, which must snap.
		add_move('0, '0, '0, '0);
		add_move(Q_MAX, Q_MAX, Q_MIN, Q_MIN);
		add_move(Q_MIN, Q_MIN, Q_MAX, Q_MAX);
		add_move(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		add_move(Q_MIN, Q_MAX, '0, '0);
		add_move('0, '0, Q_MIN, Q_MAX);
		add_move(32'sd65536, -32'sd65536, '0, '0);
		add_move(32'sd1, -32'sd1, '0, '0);
		repeat (3) add_move('0, '0, Q_100, Q_100);
		add_move(Q_100 - 1, Q_100 - 1, Q_100, Q_100);
		add_move(Q_100, Q_100, Q_100, Q_100);
		add_move(-Q_100, Q_100, 32'sh5555_5555, 32'shAAAA_AAAA);
		add_move(32'shAAAA_AAAA, 32'sh5555_5555, -32'sd1, 32'sd1);
		queue_random_items(PHASE_ITEMS);

		// Settle time below its floor with a huge step (decay zero), no speed
		// at all, the longest settle time with a zero step, a mid-range decay
		// and a clamped offset.
		run_phase(32'd0, 32'h7FFF_FFFF, 32'd65535);
		run_phase(32'd5, 32'd0, 32'd1);
		run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
		run_phase(32'd3277, 32'h7FFF_FFFF, 32'd6554);
		run_phase(32'd65536, 32'd131072, 32'd1092);

		while (random_issued < RANDOM_ITEMS) begin
			st = $urandom >> $urandom_range(1, 30);
			st[31] = $urandom_range(0, 1);
			ms = $urandom >> $urandom_range(0, 31);
			ms[31] = $urandom_range(0, 1);
			ts = $urandom;
			ts[15:0] = ts[15:0] >> $urandom_range(0, 15);
			wait_idle();
			write_reg(REG_SPARE, $urandom);
			run_phase(st, ms, ts);
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (!mismatch_seen && expected_moves.size() == 0) begin
			$display("[vector_smooth_damp] OK");
		end else begin
			$display("[vector_smooth_damp] ERROR");
		end
		$finish;
	end

endmodule

### sim.f
hdl/vsd_pkg.sv
hdl/vsd_if.sv
hdl/vsd_coef.sv
hdl/vsd_lane.sv
hdl/vsd_merge.sv
hdl/vector_smooth_damp.sv
tb/sv/testbench.sv
